// ----- rtl/rbrt_pkg.sv -----
// ----------------------------------------------------------------------------
// rbrt_pkg
// Types, constants and helpers shared by the ray and box rotation transform.
// ----------------------------------------------------------------------------
package rbrt_pkg;

   localparam int COEF_W    = 16;
   localparam int ROW_W     = 3 * COEF_W;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = COEF_W + DATA_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int COEF_FRAC = 14;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FWD_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW2 = 3'd5;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

   typedef enum logic [1:0] {
      MODE_INV_RAY = 2'd0,
      MODE_FWD_RAY = 2'd1,
      MODE_NORMAL  = 2'd2,
      MODE_BOX     = 2'd3
   } mode_type;

   typedef logic [2:0][ROW_W-1:0] rows_type;

   typedef struct packed {
      mode_type                mode;
      logic                    item_valid;
      logic [2:0][DATA_W-1:0]  a;
      logic [2:0][DATA_W-1:0]  b;
   } item_type;

   typedef struct packed {
      mode_type                    mode;
      logic                        item_valid;
      logic [2:0][DATA_W-1:0]      a;
      logic [2:0][2:0][PROD_W-1:0] pa;
      logic [2:0][2:0][PROD_W-1:0] pb;
   } prod_type;

   typedef struct packed {
      logic [2:0][DATA_W-1:0] a;
      logic [2:0][DATA_W-1:0] b;
      logic                   valid;
   } result_type;

   // round half up, then saturate to signed 32 bits
   function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      t = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (t > SAT_MAX) begin
         round_sat = SAT_MAX[DATA_W-1:0];
      end else if (t < SAT_MIN) begin
         round_sat = SAT_MIN[DATA_W-1:0];
      end else begin
         round_sat = t[DATA_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/rbrt_mult.sv -----
// ----------------------------------------------------------------------------
// rbrt_mult
// Matrix select by mode and the eighteen coefficient by component products.
// ----------------------------------------------------------------------------
module rbrt_mult (
   input  rbrt_pkg::item_type  item,
   input  rbrt_pkg::rows_type  fwd_rows,
   input  rbrt_pkg::rows_type  inv_rows,
   output rbrt_pkg::prod_type  prod
);

   always_comb begin
      logic signed [rbrt_pkg::COEF_W-1:0] coef;
      logic signed [rbrt_pkg::DATA_W-1:0] av;
      logic signed [rbrt_pkg::DATA_W-1:0] bv;
      logic signed [rbrt_pkg::PROD_W-1:0] ma;
      logic signed [rbrt_pkg::PROD_W-1:0] mb;
      prod.mode       = item.mode;
      prod.item_valid = item.item_valid;
      prod.a          = item.a;
      prod.pa         = '0;
      prod.pb         = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            case (item.mode)
               rbrt_pkg::MODE_INV_RAY: begin
                  coef = inv_rows[r][c*rbrt_pkg::COEF_W +: rbrt_pkg::COEF_W];
               end
               rbrt_pkg::MODE_NORMAL: begin
                  coef = inv_rows[c][r*rbrt_pkg::COEF_W +: rbrt_pkg::COEF_W];
               end
               default: begin
                  coef = fwd_rows[r][c*rbrt_pkg::COEF_W +: rbrt_pkg::COEF_W];
               end
            endcase
            av = item.a[c];
            bv = item.b[c];
            ma = coef * av;
            mb = coef * bv;
            prod.pa[r][c] = ma;
            prod.pb[r][c] = mb;
         end
      end
   end

endmodule

// ----- rtl/rbrt_reduce.sv -----
// ----------------------------------------------------------------------------
// rbrt_reduce
// Row sums (or per-term min/max sums for boxes), rounding, saturation and
// the mode specific result selection.
// ----------------------------------------------------------------------------
module rbrt_reduce (
   input  rbrt_pkg::prod_type    prod,
   output rbrt_pkg::result_type  res
);

   always_comb begin
      logic signed [rbrt_pkg::ACC_W-1:0] xa;
      logic signed [rbrt_pkg::ACC_W-1:0] xb;
      logic signed [rbrt_pkg::ACC_W-1:0] sum_lo;
      logic signed [rbrt_pkg::ACC_W-1:0] sum_hi;
      logic [2:0][rbrt_pkg::DATA_W-1:0]  ra;
      logic [2:0][rbrt_pkg::DATA_W-1:0]  rb;
      ra = '0;
      rb = '0;
      for (int r = 0; r < 3; r++) begin
         sum_lo = '0;
         sum_hi = '0;
         for (int c = 0; c < 3; c++) begin
            xa = {{(rbrt_pkg::ACC_W-rbrt_pkg::PROD_W){prod.pa[r][c][rbrt_pkg::PROD_W-1]}},
                  prod.pa[r][c]};
            xb = {{(rbrt_pkg::ACC_W-rbrt_pkg::PROD_W){prod.pb[r][c][rbrt_pkg::PROD_W-1]}},
                  prod.pb[r][c]};
            // box bounds: each term picks its own extreme corner
            if (prod.mode == rbrt_pkg::MODE_BOX) begin
               sum_lo = sum_lo + ((xa < xb) ? xa : xb);
               sum_hi = sum_hi + ((xa < xb) ? xb : xa);
            end else begin
               sum_lo = sum_lo + xa;
               sum_hi = sum_hi + xb;
            end
         end
         ra[r] = rbrt_pkg::round_sat(sum_lo);
         rb[r] = rbrt_pkg::round_sat(sum_hi);
      end

      case (prod.mode)
         rbrt_pkg::MODE_NORMAL: begin
            res.a     = prod.item_valid ? ra : prod.a;
            res.b     = '0;
            res.valid = prod.item_valid;
         end
         rbrt_pkg::MODE_BOX: begin
            res.a     = prod.item_valid ? ra : '0;
            res.b     = prod.item_valid ? rb : '0;
            res.valid = prod.item_valid;
         end
         default: begin
            res.a     = ra;
            res.b     = rb;
            res.valid = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/ray_and_box_rotation_transform_top.sv -----
// ----------------------------------------------------------------------------
// ray_and_box_rotation_transform_top
// Rotates rays, hit normals and boxes by a programmed 3x3 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write the forward rows (index 0..2) and inverse rows (3..5), three
//            signed Q1.14 coefficients each, while no transaction is in flight.
//   req_*  : one transaction per item; accepted when req_valid is high and
//            req_stall is low.
//   rsp_*  : one result transaction per item, in order; taken when rsp_valid
//            is high and rsp_stall is low.
// Three register stages: input register, product register (matrix select and
// 16x32 multiplies), result register (sums, box min/max, rounding and
// saturation). rsp_valid rises when an accepted transaction reaches the result
// register. Throughput is one transaction per cycle while rsp_stall is low.
// A stall on rsp_ stops the pipeline from the back; empty stages keep filling,
// so req_stall rises only when all three stages hold a transaction.
// Reset clears all stage valid bits and sets every matrix coefficient to 0.
// ----------------------------------------------------------------------------
module ray_and_box_rotation_transform_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_we,
   input  logic [rbrt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbrt_pkg::ROW_W-1:0]          csr_wdata,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic signed [31:0]                  req_vec_a_x,
   input  logic signed [31:0]                  req_vec_a_y,
   input  logic signed [31:0]                  req_vec_a_z,
   input  logic signed [31:0]                  req_vec_b_x,
   input  logic signed [31:0]                  req_vec_b_y,
   input  logic signed [31:0]                  req_vec_b_z,
   input  logic                                req_item_valid,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_out_a_x,
   output logic signed [31:0]                  rsp_out_a_y,
   output logic signed [31:0]                  rsp_out_a_z,
   output logic signed [31:0]                  rsp_out_b_x,
   output logic signed [31:0]                  rsp_out_b_y,
   output logic signed [31:0]                  rsp_out_b_z,
   output logic                                rsp_out_valid
);

   rbrt_pkg::rows_type   fwd_ff, fwd_in;
   rbrt_pkg::rows_type   inv_ff, inv_in;

   logic                 v1_ff, v1_in;
   logic                 v2_ff, v2_in;
   logic                 v3_ff, v3_in;
   logic                 ready1, ready2, ready3;

   rbrt_pkg::item_type   item_ff, item_in;
   rbrt_pkg::prod_type   prod_ff, prod_in;
   rbrt_pkg::prod_type   prod_calc;
   rbrt_pkg::result_type res_ff, res_in;
   rbrt_pkg::result_type res_calc;

   // configuration
   always_comb begin
      fwd_in = fwd_ff;
      inv_in = inv_ff;
      if (csr_we) begin
         case (csr_index)
            rbrt_pkg::CSR_FWD_ROW0: fwd_in[0] = csr_wdata;
            rbrt_pkg::CSR_FWD_ROW1: fwd_in[1] = csr_wdata;
            rbrt_pkg::CSR_FWD_ROW2: fwd_in[2] = csr_wdata;
            rbrt_pkg::CSR_INV_ROW0: inv_in[0] = csr_wdata;
            rbrt_pkg::CSR_INV_ROW1: inv_in[1] = csr_wdata;
            rbrt_pkg::CSR_INV_ROW2: inv_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control
   assign ready3    = !v3_ff || !rsp_stall;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;

   assign v1_in = ready1 ? req_valid : v1_ff;
   assign v2_in = ready2 ? v1_ff     : v2_ff;
   assign v3_in = ready3 ? v2_ff     : v3_ff;

   always_comb begin
      item_in = item_ff;
      if (req_valid && ready1) begin
         item_in.mode       = rbrt_pkg::mode_type'(req_mode);
         item_in.item_valid = req_item_valid;
         item_in.a          = {req_vec_a_z, req_vec_a_y, req_vec_a_x};
         item_in.b          = {req_vec_b_z, req_vec_b_y, req_vec_b_x};
      end
   end

   rbrt_mult u_mult (
      .item     (item_ff),
      .fwd_rows (fwd_ff),
      .inv_rows (inv_ff),
      .prod     (prod_calc)
   );

   assign prod_in = (v1_ff && ready2) ? prod_calc : prod_ff;

   rbrt_reduce u_reduce (
      .prod (prod_ff),
      .res  (res_calc)
   );

   assign res_in = (v2_ff && ready3) ? res_calc : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         inv_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
         inv_ff <= inv_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign rsp_valid     = v3_ff;
   assign rsp_out_a_x   = res_ff.a[0];
   assign rsp_out_a_y   = res_ff.a[1];
   assign rsp_out_a_z   = res_ff.a[2];
   assign rsp_out_b_x   = res_ff.b[0];
   assign rsp_out_b_y   = res_ff.b[1];
   assign rsp_out_b_z   = res_ff.b[2];
   assign rsp_out_valid = res_ff.valid;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("input stalled while pipeline has room");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted transaction lost at input stage");

   a_prod_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ready3) |=> (v2_ff && $stable(prod_ff)))
      else $error("product stage changed while blocked");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rsp_stall && !v2_ff) |=> !rsp_valid)
      else $error("result transaction repeated");

endmodule
